@@ design/pfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg: shared types, constants and helpers of the playfair encryptor
// Request kinds, controller states, command and status structs, and the
// letter and square position helpers used by the controller and datapath.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam logic [4:0] SQ_SIDE     = 5'd5;
  localparam logic [4:0] SQ_CELLS    = 5'd25;
  localparam logic [4:0] ALPHA       = 5'd26;
  localparam logic [4:0] LAST_LETTER = 5'd25;
  localparam logic [4:0] LET_I       = 5'd8;
  localparam logic [4:0] LET_J       = 5'd9;
  localparam logic [4:0] LET_X       = 5'd23;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_MSG    = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FINISH = 4'b0010,
    ST_CELL   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  typedef struct packed {
    logic key_place;
    logic clear;
    logic fin_start;
    logic fin_step;
    logic fin_done;
    logic pend_load;
    logic pend_clear;
    logic pair_start;
    logic pair_fill;
    logic cell_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sq_ready;
    logic pend_valid;
    logic match;
    logic in_range;
    logic fill_full;
    logic fin_last;
    logic out_busy;
  } sts_t;

  function automatic logic [4:0] fold_j(logic [4:0] v);
    return (v == LET_J) ? LET_I : v;
  endfunction

  // row of a cell index below 25, by reciprocal multiply
  function automatic logic [2:0] pos_row(logic [4:0] p);
    logic [9:0] prod;
    prod = 10'(p) * 10'd13;
    return prod[8:6];
  endfunction

  function automatic logic [2:0] pos_col(logic [4:0] p);
    logic [2:0] r;
    logic [4:0] base;
    r    = pos_row(p);
    base = 5'({r, 2'b00}) + 5'(r);
    return 3'(p - base);
  endfunction

  function automatic logic [2:0] wrap_inc(logic [2:0] v);
    return (v == 3'(SQ_SIDE - 5'd1)) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cell_idx(logic [2:0] r, logic [2:0] c);
    return 5'({r, 2'b00}) + 5'(r) + 5'(c);
  endfunction

endpackage

@@ design/pfc_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_req_if: request channel of the playfair encryptor
// Valid/ready channel carrying the request kind and its letter.
// ----------------------------------------------------------------------------
interface pfc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] letter;

  modport source (output valid, kind, letter, input ready);
  modport sink   (input valid, kind, letter, output ready);
endinterface

@@ design/pfc_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_rsp_if: cipher output channel of the playfair encryptor
// Valid/ready channel carrying one cipher letter and the end-of-pair flag.
// ----------------------------------------------------------------------------
interface pfc_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] cipher_letter;
  logic       last;

  modport source (output valid, cipher_letter, last, input ready);
  modport sink   (input valid, cipher_letter, last, output ready);
endinterface

@@ design/pfc_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_cfg_if: configuration write channel of the playfair encryptor
// Valid/ready channel carrying the filler letter register value.
// ----------------------------------------------------------------------------
interface pfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] filler_letter;

  modport source (output valid, filler_letter, input ready);
  modport sink   (input valid, filler_letter, output ready);
endinterface

@@ design/pfc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_ctrl: controller of the playfair encryptor
// Decodes each request against the datapath status, sequences the square
// completion walk and the two-step pair lookup, and issues datapath commands.
// ----------------------------------------------------------------------------
module pfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic [1:0]    req_kind_i,
  output logic          req_ready_o,
  input  pfc_pkg::sts_t sts_i,
  output pfc_pkg::cmd_t cmd_o
);
  import pfc_pkg::*;

  state_e state_q, state_d;
  kind_e  kind;

  assign kind = kind_e'(req_kind_i);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (kind)
            KIND_KEY: begin
              if (sts_i.in_range) begin
                cmd_o.key_place = 1'b1;
                cmd_o.clear     = sts_i.sq_ready | sts_i.fill_full;
              end
            end
            KIND_FINISH: begin
              if (!sts_i.sq_ready) begin
                cmd_o.fin_start = 1'b1;
                state_d         = ST_FINISH;
              end
            end
            KIND_MSG: begin
              if (sts_i.sq_ready && sts_i.in_range) begin
                if (!sts_i.pend_valid) begin
                  cmd_o.pend_load = 1'b1;
                end else if (sts_i.match) begin
                  cmd_o.pair_start = 1'b1;
                  cmd_o.pair_fill  = 1'b1;
                  cmd_o.pend_load  = 1'b1;
                  state_d          = ST_CELL;
                end else begin
                  cmd_o.pair_start = 1'b1;
                  cmd_o.pend_clear = 1'b1;
                  state_d          = ST_CELL;
                end
              end
            end
            KIND_END: begin
              if (sts_i.sq_ready && sts_i.pend_valid) begin
                cmd_o.pair_start = 1'b1;
                cmd_o.pair_fill  = 1'b1;
                cmd_o.pend_clear = 1'b1;
                state_d          = ST_CELL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FINISH: begin
        cmd_o.fin_step = 1'b1;
        if (sts_i.fin_last) begin
          cmd_o.fin_done = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_CELL: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/pfc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_dp: datapath of the playfair encryptor
// Square and position memories, fill and presence tracking, open pair,
// pair rule evaluation and the two-letter output stage.
// ----------------------------------------------------------------------------
module pfc_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfc_pkg::cmd_t cmd_i,
  output pfc_pkg::sts_t sts_o,
  input  logic [4:0]    letter_i,
  input  logic [4:0]    filler_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [4:0]    cipher_letter_o,
  output logic          last_o
);
  import pfc_pkg::*;

  logic [4:0] sq_mem  [25];
  logic [4:0] pos_mem [26];

  logic [25:0] present_q, present_d, present_base;
  logic [4:0]  fill_q, fill_d, fill_base;
  logic        ready_q, ready_d;
  logic        pend_valid_q, pend_valid_d;
  logic [4:0]  pend_letter_q, pend_letter_d;
  logic [4:0]  fin_cnt_q, fin_cnt_d;

  logic [4:0] pa_q, pb_q;
  logic [4:0] x_q, y_q;
  logic [4:0] ox_q, oy_q;
  logic       out_valid_q, out_valid_d;
  logic       out_second_q, out_second_d;

  logic [4:0] v_let, fill_let, fill_raw, place_let, b_let;
  logic       do_place;
  logic [2:0] ra, ca, rb, cb, xr, xc, yr, yc;
  logic [4:0] xi, yi;

  assign v_let    = fold_j(letter_i);
  assign fill_raw = (filler_i < ALPHA) ? filler_i : LET_X;
  assign fill_let = fold_j(fill_raw);
  assign b_let    = cmd_i.pair_fill ? fill_let : v_let;

  // placement into the square, shared by key letters and the finish walk
  assign place_let    = cmd_i.fin_step ? fin_cnt_q : v_let;
  assign present_base = cmd_i.clear ? '0 : present_q;
  assign fill_base    = cmd_i.clear ? '0 : fill_q;
  assign do_place     = (cmd_i.key_place | cmd_i.fin_step) && (place_let != LET_J)
                        && !present_base[place_let] && (fill_base < SQ_CELLS);

  always_comb begin
    present_d = present_base;
    if (do_place) begin
      present_d = present_base | (26'd1 << place_let);
    end
    fill_d = fill_base + 5'(do_place);

    ready_d = ready_q;
    if (cmd_i.clear) begin
      ready_d = 1'b0;
    end else if (cmd_i.fin_done) begin
      ready_d = 1'b1;
    end

    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    if (cmd_i.pend_load) begin
      pend_valid_d  = 1'b1;
      pend_letter_d = v_let;
    end else if (cmd_i.pend_clear || cmd_i.clear || cmd_i.fin_done) begin
      pend_valid_d = 1'b0;
    end

    fin_cnt_d = fin_cnt_q;
    if (cmd_i.fin_start) begin
      fin_cnt_d = '0;
    end else if (cmd_i.fin_step) begin
      fin_cnt_d = fin_cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q     <= '0;
      fill_q        <= '0;
      ready_q       <= 1'b0;
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
      fin_cnt_q     <= '0;
    end else begin
      present_q     <= present_d;
      fill_q        <= fill_d;
      ready_q       <= ready_d;
      pend_valid_q  <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
      fin_cnt_q     <= fin_cnt_d;
    end
  end

  // position memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (do_place) begin
      pos_mem[place_let] <= fill_base;
    end
    if (cmd_i.pair_start) begin
      pa_q <= pos_mem[pend_letter_q];
      pb_q <= pos_mem[b_let];
    end
  end

  // pair rules
  always_comb begin
    ra = pos_row(pa_q);
    ca = pos_col(pa_q);
    rb = pos_row(pb_q);
    cb = pos_col(pb_q);
    if (ra == rb) begin
      xr = ra;
      xc = wrap_inc(ca);
      yr = rb;
      yc = wrap_inc(cb);
    end else if (ca == cb) begin
      xr = wrap_inc(ra);
      xc = ca;
      yr = wrap_inc(rb);
      yc = cb;
    end else begin
      xr = ra;
      xc = cb;
      yr = rb;
      yc = ca;
    end
    xi = cell_idx(xr, xc);
    yi = cell_idx(yr, yc);
  end

  // square memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (do_place) begin
      sq_mem[fill_base] <= place_let;
    end
    if (cmd_i.cell_rd) begin
      x_q <= sq_mem[xi];
      y_q <= sq_mem[yi];
    end
  end

  // output stage: first letter, then second with last set
  always_comb begin
    out_valid_d  = out_valid_q;
    out_second_d = out_second_q;
    if (cmd_i.out_load) begin
      out_valid_d  = 1'b1;
      out_second_d = 1'b0;
    end else if (out_valid_q && out_ready_i) begin
      if (out_second_q) begin
        out_valid_d = 1'b0;
      end else begin
        out_second_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_second_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      out_second_q <= out_second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ox_q <= x_q;
      oy_q <= y_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_letter_o = out_second_q ? oy_q : ox_q;
  assign last_o          = out_second_q;

  assign sts_o.sq_ready   = ready_q;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.match      = (v_let == pend_letter_q);
  assign sts_o.in_range   = (letter_i < ALPHA);
  assign sts_o.fill_full  = (fill_q >= SQ_CELLS);
  assign sts_o.fin_last   = (fin_cnt_q == LAST_LETTER);
  assign sts_o.out_busy   = out_valid_q;

  a_fin_fills_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin_done |=> (ready_q && fill_q == SQ_CELLS))
    else $error("square not complete after finish walk");

  a_pair_needs_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pair_start |-> ready_q)
    else $error("pair started on an unfinished square");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q)
    else $error("output stage overwritten");

  a_pair_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && out_second_q) |=> !out_valid_q)
    else $error("output stage still valid after second letter");

endmodule

@@ design/playfair_cipher_encryptor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_cipher_encryptor: playfair encryptor over a 5x5 square
// Builds the square from key requests and encrypts message letters in pairs.
// ----------------------------------------------------------------------------
// req_i carries kind and letter: key letter, finish square, message letter or
// end of message. rsp_o delivers cipher letters, two per encrypted pair, with
// last set on the second. cfg_i writes the filler letter (reset x) and is
// always ready; write it only while the block is idle.
// Sequencing: a key letter, a message letter that only opens a pair, or an
// ignored request is taken without leaving the idle state. A finish request
// walks the alphabet letter by letter through the single square write port.
// A pair-closing request passes a position memory read, a square memory read
// and a load into the output stage; its first cipher letter is valid in the
// cycle after the load and the second in the cycle after the receiver takes
// the first. The output stage holds one pair, so the next request is taken
// while it drains; a further pair waits in its load step while the receiver
// stalls. Reset clears the square, the open pair and the output stage; the
// block is ready to take requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module playfair_cipher_encryptor (
  input  logic clk_i,
  input  logic rst_ni,
  pfc_req_if.sink   req_i,
  pfc_rsp_if.source rsp_o,
  pfc_cfg_if.sink   cfg_i
);
  import pfc_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [4:0] filler_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filler_q <= LET_X;
    end else if (cfg_i.valid) begin
      filler_q <= cfg_i.filler_letter;
    end
  end

  pfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .letter_i        (req_i.letter),
    .filler_i        (filler_q),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .cipher_letter_o (rsp_o.cipher_letter),
    .last_o          (rsp_o.last)
  );

endmodule
